### sv/titt_pkg.sv
// ----------------------------------------------------------------------------
// titt_pkg : shared types for the timer table
// Request actions, result kinds, slot record layout and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package titt_pkg;

    localparam int TITT_NUM_SLOTS = 16;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_ADD    = 2'd1,
        ACT_CANCEL = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        KIND_FIRED     = 3'd0,
        KIND_DONE      = 3'd1,
        KIND_ADDED     = 3'd2,
        KIND_FULL      = 3'd3,
        KIND_CANCELLED = 3'd4,
        KIND_NOT_FOUND = 3'd5
    } t_kind;

    // one slot record as held in the table memory
    typedef struct packed {
        logic        once;
        logic [31:0] delay;
        logic [31:0] stamp;
        logic [31:0] ident;
    } t_slot;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_FIN  = 3'b100
    } t_state;

endpackage

`default_nettype wire

### sv/timeout_interval_timer_table.sv
// ----------------------------------------------------------------------------
// timeout_interval_timer_table : table of one-shot and periodic timers
//
//  channel  dir  tdata                                       tuser
//  s_axis   in   [31:0] delay_ticks [32] one_shot             [1:0] action
//                [64:33] cancel_id [71:65] zero
//  m_axis   out  [31:0] timer_id                             [2:0] kind, tlast=last
//
// Every request other than an ignored action code walks the slots in order,
// one slot per cycle, through a registered read of the slot memory; the walk
// runs to the end on a tick, full add or unknown cancel, and stops when add or cancel hits.
// An emitted result holds the walk only while the output register is full.
// Reset clears time, id counter and valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module timeout_interval_timer_table
    import titt_pkg::*;
#(
    parameter int NUM_SLOTS = TITT_NUM_SLOTS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [31:0] delay_ticks, [32] one_shot, [64:33] cancel_id, [71:65] zero
    input  wire logic [71:0] i_s_axis_tdata,
    // [1:0] action
    input  wire logic [1:0]  i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [31:0] timer_id
    output logic [31:0]      o_m_axis_tdata,
    // [2:0] kind
    output logic [2:0]       o_m_axis_tuser,
    output logic             o_m_axis_tlast
);

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

    t_state                r_state, n_state;
    t_action               r_action, n_action;
    logic [31:0]           r_delay, n_delay;
    logic                  r_once, n_once;
    logic [31:0]           r_cid, n_cid;
    logic [31:0]           r_time, n_time;
    logic [31:0]           r_idctr, n_idctr;
    logic [NUM_SLOTS-1:0]  r_valid, n_valid;
    logic [IW-1:0]         r_idx, n_idx;
    logic                  r_out_valid, n_out_valid;
    t_kind                 r_out_kind, n_out_kind;
    logic [31:0]           r_out_id, n_out_id;
    logic                  r_out_last, n_out_last;

    t_slot                 r_mem [NUM_SLOTS];
    t_slot                 r_rdata;

    logic                  s_accept;
    logic                  out_free;
    logic                  hit;
    logic [31:0]           elapsed;
    logic                  rd_en;
    logic [IW-1:0]         rd_addr;
    logic                  wr_en;
    t_slot                 wr_data;
    logic                  emit;
    t_kind                 e_kind;
    logic [31:0]           e_id;
    logic                  e_last;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign elapsed         = r_time - r_rdata.stamp;

    always_comb begin
        unique case (r_action)
            ACT_TICK:   hit = r_valid[r_idx] && (elapsed > r_rdata.delay);
            ACT_ADD:    hit = !r_valid[r_idx];
            ACT_CANCEL: hit = r_valid[r_idx] && (r_rdata.ident == r_cid);
            default:    hit = 1'b0;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_action = r_action;
        n_delay  = r_delay;
        n_once   = r_once;
        n_cid    = r_cid;
        n_time   = r_time;
        n_idctr  = r_idctr;
        n_valid  = r_valid;
        n_idx    = r_idx;
        rd_en    = 1'b0;
        rd_addr  = r_idx + IW'(1);
        wr_en    = 1'b0;
        wr_data  = r_rdata;
        emit     = 1'b0;
        e_kind   = KIND_DONE;
        e_id     = '0;
        e_last   = 1'b1;

        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_action = t_action'(i_s_axis_tuser);
                    n_delay  = i_s_axis_tdata[31:0];
                    n_once   = i_s_axis_tdata[32];
                    n_cid    = i_s_axis_tdata[64:33];
                    if (t_action'(i_s_axis_tuser) != ACT_NONE) begin
                        n_state = ST_SCAN;
                        n_idx   = '0;
                        rd_en   = 1'b1;
                        rd_addr = '0;
                    end
                    if (t_action'(i_s_axis_tuser) == ACT_TICK) begin
                        n_time = r_time + 32'd1;
                    end
                end
            end
            ST_SCAN: begin
                // hold the slot data while a result is blocked
                if (!(hit && !out_free)) begin
                    if (hit) begin
                        emit = 1'b1;
                        unique case (r_action)
                            ACT_TICK: begin
                                wr_en         = 1'b1;
                                wr_data.stamp = r_time;
                                if (r_rdata.once) begin
                                    n_valid[r_idx] = 1'b0;
                                end
                                e_kind = KIND_FIRED;
                                e_id   = r_rdata.ident;
                                e_last = 1'b0;
                            end
                            ACT_ADD: begin
                                wr_en          = 1'b1;
                                wr_data.once   = r_once;
                                wr_data.delay  = r_delay;
                                wr_data.stamp  = r_time;
                                wr_data.ident  = r_idctr + 32'd1;
                                n_valid[r_idx] = 1'b1;
                                n_idctr        = r_idctr + 32'd1;
                                e_kind         = KIND_ADDED;
                                e_id           = r_idctr + 32'd1;
                                n_state        = ST_IDLE;
                            end
                            default: begin
                                n_valid[r_idx] = 1'b0;
                                e_kind         = KIND_CANCELLED;
                                n_state        = ST_IDLE;
                            end
                        endcase
                    end
                    if (!hit || r_action == ACT_TICK) begin
                        if (r_idx == LAST_IDX) begin
                            n_state = ST_FIN;
                        end else begin
                            n_idx = r_idx + IW'(1);
                            rd_en = 1'b1;
                        end
                    end
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = ST_IDLE;
                    unique case (r_action)
                        ACT_ADD:    e_kind = KIND_FULL;
                        ACT_CANCEL: e_kind = KIND_NOT_FOUND;
                        default:    e_kind = KIND_DONE;
                    endcase
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        n_out_valid = r_out_valid;
        n_out_kind  = r_out_kind;
        n_out_id    = r_out_id;
        n_out_last  = r_out_last;
        if (emit) begin
            n_out_valid = 1'b1;
            n_out_kind  = e_kind;
            n_out_id    = e_id;
            n_out_last  = e_last;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    // slot memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_idx] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_time      <= '0;
            r_idctr     <= '0;
            r_valid     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_time      <= n_time;
            r_idctr     <= n_idctr;
            r_valid     <= n_valid;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action   <= n_action;
        r_delay    <= n_delay;
        r_once     <= n_once;
        r_cid      <= n_cid;
        r_out_kind <= n_out_kind;
        r_out_id   <= n_out_id;
        r_out_last <= n_out_last;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_id;
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    a_tick_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && i_s_axis_tuser == ACT_TICK) |=> (r_time == $past(r_time) + 32'd1))
        else $error("time not advanced by tick");

    a_added_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_ADDED) |-> (r_out_id == r_idctr))
        else $error("added id differs from id counter");

    a_fired_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_FIRED) |-> !r_out_last)
        else $error("fired result marked last");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= LAST_IDX)
        else $error("slot index out of range");

    a_one_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) <= $countones($past(r_valid)) + 1)
        else $error("more than one slot filled at once");
`endif

endmodule

`default_nettype wire

### tb/timer_sb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timer_sb_pkg : scoreboard for the timer table
// Keeps a shadow copy of the slot table, works out the results every accepted
// request should cause and checks the result stream against them in order.
// ----------------------------------------------------------------------------
package timer_sb_pkg;

    import titt_pkg::*;

    typedef struct {
        t_kind       kind;
        logic [31:0] timer_id;
        logic        last;
    } timer_event_t;

    class timer_scoreboard;
        logic [31:0]  now_ticks;
        logic [31:0]  last_id;
        bit           armed  [TITT_NUM_SLOTS];
        bit           single [TITT_NUM_SLOTS];
        logic [31:0]  period [TITT_NUM_SLOTS];
        logic [31:0]  stamp  [TITT_NUM_SLOTS];
        logic [31:0]  ident  [TITT_NUM_SLOTS];
        timer_event_t due_q[$];
        int unsigned  n_errors;

        function new();
            now_ticks = '0;
            last_id   = '0;
            n_errors  = 0;
            foreach (armed[i]) begin
                armed[i]  = 1'b0;
                single[i] = 1'b0;
                period[i] = '0;
                stamp[i]  = '0;
                ident[i]  = '0;
            end
        endfunction

        function void push_event(t_kind kind, logic [31:0] id, logic last);
            timer_event_t ev;
            ev.kind     = kind;
            ev.timer_id = id;
            ev.last     = last;
            due_q.push_back(ev);
        endfunction

        // apply one accepted request to the shadow table
        function void log_request(t_action act, logic [31:0] dly, logic once,
                                  logic [31:0] cid);
            logic [31:0] elapsed;
            bit          hit;
            hit = 1'b0;
            case (act)
                ACT_TICK: begin
                    now_ticks = now_ticks + 32'd1;
                    // every slot is visited once, freeing does not shift the walk
                    for (int i = 0; i < TITT_NUM_SLOTS; i++) begin
                        elapsed = now_ticks - stamp[i];
                        if (armed[i] && elapsed > period[i]) begin
                            stamp[i] = now_ticks;
                            if (single[i])
                                armed[i] = 1'b0;
                            push_event(KIND_FIRED, ident[i], 1'b0);
                        end
                    end
                    push_event(KIND_DONE, '0, 1'b1);
                end
                ACT_ADD: begin
                    for (int i = 0; i < TITT_NUM_SLOTS; i++) begin
                        if (!hit && !armed[i]) begin
                            hit       = 1'b1;
                            last_id   = last_id + 32'd1;
                            armed[i]  = 1'b1;
                            single[i] = once;
                            period[i] = dly;
                            stamp[i]  = now_ticks;
                            ident[i]  = last_id;
                        end
                    end
                    if (hit)
                        push_event(KIND_ADDED, last_id, 1'b1);
                    else
                        push_event(KIND_FULL, '0, 1'b1);
                end
                ACT_CANCEL: begin
                    // lowest matching slot only
                    for (int i = 0; i < TITT_NUM_SLOTS; i++) begin
                        if (!hit && armed[i] && ident[i] == cid) begin
                            hit      = 1'b1;
                            armed[i] = 1'b0;
                        end
                    end
                    if (hit)
                        push_event(KIND_CANCELLED, '0, 1'b1);
                    else
                        push_event(KIND_NOT_FOUND, '0, 1'b1);
                end
                default: ;
            endcase
        endfunction

        function void check_event(logic [2:0] kind, logic [31:0] id, logic last);
            timer_event_t want;
            if (due_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result: kind %0d id 0x%08h last %0b",
                             kind, id, last);
            end else begin
                want = due_q.pop_front();
                if (want.kind != kind || want.timer_id != id || want.last != last) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch: want kind %0d id 0x%08h last %0b, %s",
                                 want.kind, want.timer_id, want.last,
                                 $sformatf("got kind %0d id 0x%08h last %0b",
                                           kind, id, last));
                end
            end
        endfunction

        function int unsigned pending();
            return due_q.size();
        endfunction

        // id of a random live timer, or a random value if the table is empty
        function logic [31:0] pick_live_id();
            int live[$];
            for (int i = 0; i < TITT_NUM_SLOTS; i++)
                if (armed[i])
                    live.push_back(i);
            if (live.size() == 0)
                return $urandom;
            return ident[live[$urandom_range(0, live.size() - 1)]];
        endfunction
    endclass

endpackage

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top : testbench for timeout_interval_timer_table
// Directed requests cover ticks, adds, cancels, a full table and a tick that
// fires every slot; random phases follow with varying idle rates on both
// sides, an output hold-off that backs the block up and a full drain.
// ----------------------------------------------------------------------------
module tb_top;

    import titt_pkg::*;
    import timer_sb_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int SETTLE_CYCLES  = 40;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [71:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tready = 1'b0;

    wire         o_s_axis_tready;
    wire         o_m_axis_tvalid;
    wire  [31:0] o_m_axis_tdata;
    wire  [2:0]  o_m_axis_tuser;
    wire         o_m_axis_tlast;

    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned hold_req    = 0;
    int unsigned idle_cycles = 0;

    timer_scoreboard sb = new();

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    timeout_interval_timer_table dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // result monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && m_tready)
                sb.check_event(o_m_axis_tuser, o_m_axis_tdata, o_m_axis_tlast);
            if ((o_m_axis_tvalid && m_tready) || (s_tvalid && o_s_axis_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[timeout_interval_timer_table] ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // receiver: random back-pressure, plus a long hold-off on request
    initial begin
        int unsigned hold_seen;
        hold_seen = 0;
        @(negedge i_clk);
        forever begin
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                repeat (HOLDOFF_CYCLES) begin
                    m_tready <= 1'b0;
                    @(negedge i_clk);
                end
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
                @(negedge i_clk);
            end
        end
    end

    // offer one request and wait until it is taken
    task automatic send_req(input t_action act, input logic [31:0] dly,
                            input logic once, input logic [31:0] cid);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, cid, once, dly};
        s_tuser  <= act;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        sb.log_request(act, dly, once, cid);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic start_holdoff();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        hold_req <= hold_req + 1;
    endtask

    function automatic logic [31:0] rand_delay();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return $urandom_range(0, 4);
        if (roll < 82)
            return $urandom_range(5, 40);
        if (roll < 95)
            return $urandom;
        return 32'hFFFF_FFFF;
    endfunction

    // n counted requests; ignored action codes are sprinkled in as noise
    task automatic run_random(input int n);
        int          sent;
        int unsigned roll;
        logic [31:0] cid;
        sent = 0;
        while (sent < n) begin
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
                send_req(ACT_NONE, $urandom, 1'($urandom), $urandom);
            end else begin
                if (roll < 40) begin
                    send_req(ACT_TICK, $urandom, 1'($urandom), $urandom);
                end else if (roll < 72) begin
                    send_req(ACT_ADD, rand_delay(), 1'($urandom), $urandom);
                end else begin
                    cid = ($urandom_range(0, 99) < 80) ? sb.pick_live_id() : $urandom;
                    send_req(ACT_CANCEL, $urandom, 1'($urandom), cid);
                end
                sent++;
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_pct = 34;
        rx_idle_pct = 70;

        // empty table, unknown id, then one of each timer mode
        send_req(ACT_TICK, '0, 1'b0, '0);
        send_req(ACT_CANCEL, '0, 1'b0, 32'hFFFF_FFFF);
        send_req(ACT_ADD, 32'd0, 1'b1, '0);
        send_req(ACT_ADD, 32'd0, 1'b0, '0);
        send_req(ACT_ADD, 32'hFFFF_FFFF, 1'b0, '0);
        send_req(ACT_TICK, '0, 1'b0, '0);
        send_req(ACT_NONE, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        send_req(ACT_CANCEL, '0, 1'b0, 32'd3);
        send_req(ACT_CANCEL, '0, 1'b0, 32'd3);
        // fill the table, overflow it, then fire every slot in one tick
        for (int i = 0; i < TITT_NUM_SLOTS - 1; i++)
            send_req(ACT_ADD, 32'd0, 1'(i), '0);
        send_req(ACT_ADD, 32'd7, 1'b0, '0);
        send_req(ACT_TICK, '0, 1'b0, '0);

        run_random(40);
        wait_drained();

        // back the block up behind a stalled output
        tx_idle_pct = 0;
        start_holdoff();
        for (int i = 0; i < 4; i++)
            send_req(ACT_ADD, 32'd0, 1'b0, '0);
        for (int i = 0; i < 8; i++)
            send_req(ACT_TICK, '0, 1'b0, '0);
        wait_drained();

        tx_idle_pct = 70;
        rx_idle_pct = 34;
        run_random(40);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(40);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (sb.n_errors == 0 && sb.pending() == 0)
            $display("[timeout_interval_timer_table] OK");
        else
            $display("[timeout_interval_timer_table] ERROR");
        $finish;
    end

endmodule

### files.f
sv/titt_pkg.sv
sv/timeout_interval_timer_table.sv
tb/timer_sb_pkg.sv
tb/tb_top.sv
